/* design/css_pkg.sv */
// shared constants, types and the letter fold for the caseless substring search unit
`default_nettype none
package css_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int POSITION_BITS = 16;
  localparam int WIN_DEPTH     = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W         = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_REG_W     = 5;
  localparam int CHARS_W       = 64;
  localparam int START_W       = 16;
  localparam int APB_DATA_W    = 64;
  localparam int APB_ADDR_W    = 5;

  localparam logic [7:0] FOLD_BIT = 8'h20;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  typedef enum logic [1:0] {
    REG_PATTERN_LEN  = 2'd0,
    REG_PATTERN_LOW  = 2'd1,
    REG_PATTERN_HIGH = 2'd2
  } css_reg_e;

  typedef struct packed {
    logic [LEN_REG_W-1:0] len;
    logic [CHARS_W-1:0]   low_chars;
    logic [CHARS_W-1:0]   high_chars;
  } css_cfg_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } css_beat_t;

  typedef struct packed {
    logic               match_now;
    logic               found;
    logic [START_W-1:0] match_start;
    logic               position_overflow;
    logic               text_end;
  } css_result_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5a]}) begin
      r = c | FOLD_BIT;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/caseless_substring_search_unit.sv */
// top level of the caseless substring search unit with stream ports and apb config
`default_nettype none
// Streams text one character per beat and reports, for every character, whether the first
// match of the configured pattern (up to 16 characters, A to Z folded to lower case) ends
// there, whether a match has been found in this text, its start index and a position
// overflow flag. One character is taken every cycle while the result port is not stalled;
// each result passes from the input register through the window compare into the result
// register. The result register lets a new character enter while a finished result waits.
// The beat with tlast set closes the text and clears the text state. Pattern registers are
// to be written over apb only while the stream is idle; the block does not enforce this.
module caseless_substring_search_unit
  import css_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // text_char
  input  wire logic                  s_axis_tlast,   // last_char
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // match_now, found, match_start[15:0], position_overflow, zero fill
  output logic [23:0]                m_axis_tdata,
  output logic                       m_axis_tlast,   // text_end
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  css_cfg_t    cfg;
  css_beat_t   in_q;
  logic        in_valid_q, in_valid_d;
  css_result_t res;
  css_result_t out_q;
  logic        out_valid_q, out_valid_d;
  logic        s_acc, advance, step;

  css_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  css_matcher u_matcher (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .beat_i   (in_q),
    .result_o (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_acc) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_q.text_char <= s_axis_tdata;
      in_q.last_char <= s_axis_tlast;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.position_overflow, out_q.match_start,
                          out_q.found, out_q.match_now};
  assign m_axis_tlast  = out_q.text_end;

endmodule
`default_nettype wire

/* design/css_apb_regs.sv */
// apb register file holding the pattern length and pattern characters
`default_nettype none
module css_apb_regs
  import css_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output css_cfg_t                   cfg_o
);

  css_cfg_t   cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[APB_ADDR_W-1:3];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_PATTERN_LEN:  cfg_d.len        = pwdata[LEN_REG_W-1:0];
        REG_PATTERN_LOW:  cfg_d.low_chars  = pwdata[CHARS_W-1:0];
        REG_PATTERN_HIGH: cfg_d.high_chars = pwdata[CHARS_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PATTERN_LEN:  prdata = APB_DATA_W'(cfg_q.len);
      REG_PATTERN_LOW:  prdata = APB_DATA_W'(cfg_q.low_chars);
      REG_PATTERN_HIGH: prdata = APB_DATA_W'(cfg_q.high_chars);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* design/css_matcher.sv */
// character window, window compare and per-text match state
`default_nettype none
module css_matcher
  import css_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire css_cfg_t  cfg_i,
  input  wire logic      step_i,
  input  wire css_beat_t beat_i,
  output css_result_t    result_o
);

  logic [7:0]               win_q [WIN_DEPTH];
  logic [7:0]               win_d [WIN_DEPTH];
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic                     found_q, found_d;
  logic                     ovf_q, ovf_d;

  logic [LEN_W-1:0]         len_c;
  logic [7:0]               txt  [PATTERN_MAX];
  logic [7:0]               pat  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]   hit;
  logic [POSITION_BITS:0]   pos_inc;
  logic                     ovf_now;
  logic                     match;
  logic [POSITION_BITS-1:0] start_c;
  logic [START_W-1:0]       start_out;

  assign len_c = (cfg_i.len > LEN_REG_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                       : LEN_W'(cfg_i.len);
  assign pos_inc = {1'b0, pos_q} + 1'b1;
  assign ovf_now = ovf_q | (pos_q == POS_MAX);

  // txt[k] is the character k places back, txt[0] the incoming one
  always_comb begin
    txt[0] = beat_i.text_char;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      txt[k] = win_q[k-1];
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pat[i] = (i < 8) ? cfg_i.low_chars[8*(i%8) +: 8] : cfg_i.high_chars[8*(i%8) +: 8];
    end
  end

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      hit[i] = (LEN_W'(i) >= len_c) ||
               (fold(pat[i]) == fold(txt[IDX_W'(len_c - LEN_W'(1) - LEN_W'(i))]));
    end
  end

  always_comb begin
    match = 1'b0;
    if (!ovf_now && !found_q) begin
      if (len_c == '0) begin
        match = (pos_q == '0);
      end else if (pos_inc >= (POSITION_BITS+1)'(len_c)) begin
        match = &hit;
      end
    end
  end

  // first match start after this character, before the end-of-text clear
  assign start_c = !match        ? start_q :
                   (len_c == '0) ? '0
                                 : POSITION_BITS'(pos_inc - (POSITION_BITS+1)'(len_c));

  always_comb begin
    win_d   = win_q;
    pos_d   = pos_q;
    start_d = start_c;
    found_d = found_q | match;
    ovf_d   = ovf_now;
    if (!ovf_now) begin
      for (int k = WIN_DEPTH - 1; k > 0; k--) begin
        win_d[k] = win_q[k-1];
      end
      win_d[0] = beat_i.text_char;
      pos_d    = pos_inc[POSITION_BITS-1:0];
    end
    if (beat_i.last_char) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_d[k] = '0;
      end
      pos_d   = '0;
      start_d = '0;
      found_d = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  if (POSITION_BITS >= START_W) begin : g_start_cut
    assign start_out = start_c[START_W-1:0];
  end else begin : g_start_ext
    assign start_out = START_W'(start_c);
  end

  // result reflects the state after this character, before the end-of-text clear
  assign result_o.match_now         = match;
  assign result_o.found             = found_q | match;
  assign result_o.match_start       = (found_q | match) ? start_out : '0;
  assign result_o.position_overflow = ovf_now;
  assign result_o.text_end          = beat_i.last_char;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_q[k] <= '0;
      end
      pos_q   <= '0;
      start_q <= '0;
      found_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      win_q   <= win_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      found_q <= found_d;
      ovf_q   <= ovf_d;
    end
  end

  // only the first match of a text is reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && match |-> !found_q)
    else $error("second match reported in one text");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q && !(step_i && beat_i.last_char) |=> found_q && $stable(start_q))
    else $error("first match start lost before end of text");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q && !(step_i && beat_i.last_char) |=> ovf_q && $stable(pos_q))
    else $error("position moved after overflow");

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// testbench for the caseless substring search unit: match scoreboard and stream and apb drivers
module tb;
  import css_pkg::*;

  class search_scoreboard;
    logic [LEN_REG_W-1:0]     len_reg;
    logic [CHARS_W-1:0]       low_reg;
    logic [CHARS_W-1:0]       high_reg;
    logic [7:0]               history[WIN_DEPTH];
    logic [POSITION_BITS-1:0] pos;
    logic                     hit_seen;
    logic                     ovf;
    logic [START_W-1:0]       start;
    css_result_t              want_q[$];
    int                       errors;
    int                       beats;

    function new();
      len_reg  = '0;
      low_reg  = '0;
      high_reg = '0;
      errors   = 0;
      beats    = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (history[i]) history[i] = 8'h00;
      pos      = '0;
      hit_seen = 1'b0;
      start    = '0;
      ovf      = 1'b0;
    endfunction

    function void set_reg(css_reg_e r, logic [63:0] v);
      case (r)
        REG_PATTERN_LEN: len_reg = v[LEN_REG_W-1:0];
        REG_PATTERN_LOW: low_reg = v;
        REG_PATTERN_HIGH: high_reg = v;
        default: ;
      endcase
    endfunction

    function logic [7:0] lower(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? (c | FOLD_BIT) : c;
    endfunction

    function logic [7:0] pat_char(int j);
      return (j < 8) ? low_reg[8*j +: 8] : high_reg[8*(j-8) +: 8];
    endfunction

    // work out the result of one text character and queue it
    function void note_char(logic [7:0] c, logic l);
      int          n;
      bit          ok;
      css_result_t r;
      n = (int'(len_reg) > PATTERN_MAX) ? PATTERN_MAX : int'(len_reg);
      r = '0;
      if (!ovf && pos == POS_MAX) ovf = 1'b1;
      if (!ovf && !hit_seen) begin
        if (n == 0) begin
          if (pos == 0) begin
            r.match_now = 1'b1;
            start = '0;
          end
        end else if (int'(pos) + 1 >= n) begin
          ok = lower(c) == lower(pat_char(n - 1));
          for (int i = 0; i < n - 1; i++) begin
            if (lower(history[n-2-i]) != lower(pat_char(i))) ok = 1'b0;
          end
          if (ok) begin
            r.match_now = 1'b1;
            start = START_W'(int'(pos) + 1 - n);
          end
        end
        if (r.match_now) hit_seen = 1'b1;
      end
      if (!ovf) begin
        for (int i = WIN_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
        history[0] = c;
        pos++;
      end
      r.found             = hit_seen;
      r.match_start       = hit_seen ? start : '0;
      r.position_overflow = ovf;
      r.text_end          = l;
      want_q.push_back(r);
      if (l) clear_text();
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      errors++;
      $display("tb: mismatch in %s at result %0d: got %0h, want %0h", what, beats, got, want);
    endtask

    task check_result(logic [23:0] d, logic l);
      css_result_t w;
      if (want_q.size() == 0) begin
        report("unexpected beat", d, 0);
        beats++;
        return;
      end
      w = want_q.pop_front();
      if (d[0] !== w.match_now) report("match_now", d[0], w.match_now);
      if (d[1] !== w.found) report("found", d[1], w.found);
      if (d[17:2] !== w.match_start) report("match_start", d[17:2], w.match_start);
      if (d[18] !== w.position_overflow) report("position_overflow", d[18], w.position_overflow);
      if (l !== w.text_end) report("text_end", l, w.text_end);
      beats++;
    endtask
  endclass

  localparam logic [7:0] LETTERS[4] = '{8'h61, 8'h62, 8'h41, 8'h42};
  localparam logic [7:0] NEAR[4]    = '{8'h40, 8'h5b, 8'h60, 8'h7b};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = 8'h01;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  search_scoreboard sb = new();
  bit               idle_on = 1'b1;
  int               eff_len;
  logic [7:0]       text_q[$];

  caseless_substring_search_unit dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !idle_on || $urandom_range(99) >= 18;
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  function automatic logic [7:0] pick_char(bit zero_ok);
    int r;
    r = $urandom_range(9);
    if (r < 6) return LETTERS[$urandom_range(3)];
    if (r == 6) return NEAR[$urandom_range(3)];
    if (zero_ok && r == 7) return 8'($urandom_range(255));
    return 8'($urandom_range(1, 255));
  endfunction

  // pattern character as it may appear in text: random case, no zero byte
  function automatic logic [7:0] vary(logic [7:0] c);
    logic [7:0] l;
    l = sb.lower(c);
    if (c == 8'h00) return 8'h01;
    if (l >= 8'h61 && l <= 8'h7a && $urandom_range(1) == 1) return c ^ FOLD_BIT;
    return c;
  endfunction

  task automatic send_char(logic [7:0] c, logic l);
    int gap;
    gap = (idle_on && $urandom_range(99) < 18) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_char(c, l);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // setup and access phase, leaves psel high
  task automatic apb_access(css_reg_e r, bit wr, logic [63:0] v, output logic [63:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'(8 * int'(r));
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
  endtask

  task automatic write_reg(css_reg_e r, logic [63:0] v);
    logic [63:0] back;
    logic [63:0] want;
    apb_access(r, 1'b1, v, back);
    sb.set_reg(r, v);
    apb_access(r, 1'b0, '0, back);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    want = (r == REG_PATTERN_LEN) ? 64'(v[LEN_REG_W-1:0]) : v;
    if (back !== want) sb.report("register readback", back, want);
  endtask

  task automatic write_config(int n, logic [63:0] lo, logic [63:0] hi);
    write_reg(REG_PATTERN_LEN, 64'(n));
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    eff_len = (n > PATTERN_MAX) ? PATTERN_MAX : n;
  endtask

  initial begin
    int          n;
    int          p;
    int          sent;
    int          r;
    logic [63:0] lo;
    logic [63:0] hi;
    eff_len = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pattern after reset matches on the first character
    text_q = '{8'h71, 8'h62};
    send_text();
    drain();

    // only A to Z fold: at-sign and backquote differ
    write_config(3, 64'h40_5a_61, '1);
    text_q = '{8'h41, 8'h7a, 8'h60, 8'h41, 8'h5a, 8'h40};
    send_text();
    drain();

    // length above the maximum acts as full width
    write_config(31, 64'h54_53_52_51_50_4f_4e_4d, 64'h7b_60_40_5b_33_32_31_30);
    text_q = '{8'h78};
    for (int j = 0; j < PATTERN_MAX; j++) text_q.push_back(sb.lower(sb.pat_char(j)));
    send_text();
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      idle_on = (ph != 6);
      if (ph == 1) begin
        write_config(PATTERN_MAX, '1, '1);
      end else if (ph == 2) begin
        write_config(PATTERN_MAX, '0, '0);
      end else begin
        r = $urandom_range(99);
        n = (r < 8 || ph == 3) ? 0 : (r < 18) ? PATTERN_MAX :
            (r < 24) ? $urandom_range(17, 31) : $urandom_range(1, 8);
        for (int j = 0; j < 8; j++) begin
          lo[8*j +: 8] = pick_char(1);
          hi[8*j +: 8] = pick_char(1);
        end
        write_config(n, lo, hi);
      end
      sent = 0;
      while (sent < 92) begin
        n = $urandom_range(1, 30);
        text_q.delete();
        repeat (n) text_q.push_back(pick_char(0));
        if (eff_len > 0 && eff_len <= n && $urandom_range(9) < 7) begin
          repeat ($urandom_range(1, 2)) begin
            p = $urandom_range(n - eff_len);
            for (int j = 0; j < eff_len; j++) text_q[p+j] = vary(sb.pat_char(j));
          end
        end
        send_text();
        sent += n;
        if ($urandom_range(11) == 0) drain();
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(200_000);
    $display("tb: FAIL");
    $finish;
  end

endmodule

/* caseless_substring_search_unit.f */
design/css_pkg.sv
design/css_apb_regs.sv
design/css_matcher.sv
design/caseless_substring_search_unit.sv
verif/tb.sv
